[rtl/yfv_pkg.sv]
// Shared constants, types and the arctangent table for the yaw-frame velocity rotator.
package yfv_pkg;

  // CORDIC iteration count; more than the table holds acts as the table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_DEPTH   = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(ATAN_DEPTH);

  // datapath widths
  localparam int FLD_W     = 16;                  // every payload field
  localparam int CW        = 37;                  // CORDIC x/y
  localparam int ZW        = 32;                  // angle accumulator, 2^32 per turn
  localparam int ACC_W     = 33;                  // sum of two 16x16 products
  localparam int MA_W      = 27;                  // multiplier operand a
  localparam int MB_W      = 34;                  // multiplier operand b
  localparam int PROD_W    = MA_W + MB_W;
  localparam int FIN_SHIFT = 40;
  localparam int RSH_W     = PROD_W - FIN_SHIFT;
  localparam int VEL_SHIFT = 8;
  localparam int Q30_SHIFT = 30;

  localparam logic signed [MB_W-1:0]   GAIN    = MB_W'(64'sd2608131496);
  localparam logic signed [PROD_W-1:0] FIN_RND = PROD_W'(64'sd1) <<< (FIN_SHIFT - 1);
  localparam logic signed [CW-1:0]     ONE_Q30 = CW'(64'sd1) <<< Q30_SHIFT;
  localparam logic signed [RSH_W-1:0]  SAT_HI  = RSH_W'(32767);
  localparam logic signed [RSH_W-1:0]  SAT_LO  = -RSH_W'(32768);
  localparam logic [ZW-1:0]            HALF_TURN = 32'h8000_0000;
  localparam logic [ZW-1:0]            YAW_RND   = 32'h0000_8000;

  // product terms of the yaw operands, in the order they are formed
  localparam int MUL_TERMS = 4;
  localparam logic [1:0] MUL_WZ = 2'd0;
  localparam logic [1:0] MUL_XY = 2'd1;
  localparam logic [1:0] MUL_YY = 2'd2;
  localparam logic [1:0] MUL_ZZ = 2'd3;

  // input command codes
  localparam logic CMD_ORIENT = 1'b0;
  localparam logic CMD_VEL    = 1'b1;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_RATE = '0;
  localparam int PDATA_W   = 32;

  typedef struct packed {
    logic              load_in;
    logic              mul_en;
    logic              vinit;
    logic              rinit;
    logic              iter;
    logic              yaw_wr;
    logic              fin_x;
    logic              fin_y;
    logic              load_out;
    logic [STEP_W-1:0] step;
  } yfv_cmd_t;

  typedef struct packed {
    logic is_vel;
    logic vec_zero;
  } yfv_status_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/yfv_in_if.sv]
// Input channel: orientation updates and velocity commands.
interface yfv_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;

  modport source (
    output valid, command, quat_x, quat_y, quat_z, quat_w, vel_x, vel_y,
    input  ready
  );
  modport sink (
    input  valid, command, quat_x, quat_y, quat_z, quat_w, vel_x, vel_y,
    output ready
  );
endinterface

[rtl/yfv_out_if.sv]
// Result channel: rotated velocity and spin rate.
interface yfv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_vel_x;
  logic signed [15:0] out_vel_y;
  logic signed [15:0] out_spin;

  modport source (
    output valid, out_vel_x, out_vel_y, out_spin,
    input  ready
  );
  modport sink (
    input  valid, out_vel_x, out_vel_y, out_spin,
    output ready
  );
endinterface

[rtl/yfv_ctrl.sv]
// Sequencer for the yaw-frame velocity rotator: handshakes, phases and step count.
module yfv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  yfv_pkg::yfv_status_t  status,
  output yfv_pkg::yfv_cmd_t     cmd
);
  import yfv_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_VINIT = 4'd2;
  localparam logic [3:0] ST_RINIT = 4'd3;
  localparam logic [3:0] ST_ITER  = 4'd4;
  localparam logic [3:0] ST_YAW   = 4'd5;
  localparam logic [3:0] ST_FINX  = 4'd6;
  localparam logic [3:0] ST_FINY  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_TERMS - 1);
  localparam logic [STEP_W-1:0] ITER_LAST = STEP_W'(CORDIC_N - 1);

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.step  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        // a velocity command leaves on the first pass; the stray product is unused
        cmd.mul_en = 1'b1;
        if (status.is_vel) begin
          state_nxt = ST_RINIT;
        end else if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_VINIT;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_VINIT: begin
        cmd.vinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = status.vec_zero ? ST_IDLE : ST_ITER;
      end
      ST_RINIT: begin
        cmd.rinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == ITER_LAST) begin
          cnt_nxt   = '0;
          state_nxt = status.is_vel ? ST_FINX : ST_YAW;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_YAW: begin
        cmd.yaw_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FINX: begin
        cmd.fin_x = 1'b1;
        state_nxt = ST_FINY;
      end
      ST_FINY: begin
        cmd.fin_y = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/yfv_datapath.sv]
// Datapath: shared multiplier, CORDIC x/y/angle registers, yaw state and output register.
module yfv_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  yfv_pkg::yfv_cmd_t             cmd,
  output yfv_pkg::yfv_status_t          status,
  input  logic                          in_command,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_quat_x,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_quat_y,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_quat_z,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_quat_w,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_vel_x,
  input  logic signed [yfv_pkg::FLD_W-1:0] in_vel_y,
  input  logic signed [yfv_pkg::FLD_W-1:0] spin_rate,
  output logic signed [yfv_pkg::FLD_W-1:0] out_vel_x,
  output logic signed [yfv_pkg::FLD_W-1:0] out_vel_y,
  output logic signed [yfv_pkg::FLD_W-1:0] out_spin
);
  import yfv_pkg::*;

  // captured item
  logic                    cmd_r;
  logic signed [FLD_W-1:0] qx_r, qy_r, qz_r, qw_r, vx_r, vy_r;

  // yaw state
  logic [FLD_W-1:0] yaw_r, yaw_nxt;

  // accumulators and CORDIC registers
  logic signed [ACC_W-1:0] acc_y_r, acc_y_nxt, acc_x_r, acc_x_nxt;
  logic signed [CW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [ZW-1:0]           z_r, z_nxt;
  logic signed [FLD_W-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [FLD_W-1:0] ox_r, oy_r, os_r;

  // multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod, rnd;
  logic signed [ACC_W-1:0]  prod_s;
  logic signed [RSH_W-1:0]  rsh;
  logic signed [FLD_W-1:0]  sat;

  // init and step terms
  logic signed [CW-1:0] vinit_x, vinit_y, vel_x0, vel_y0, dx, dy;
  logic [FLD_W-1:0]     yaw_neg;
  logic [ZW-1:0]        t32, yaw_sum, atan_v;
  logic                 flip, y_pos, s_pos, vec_mode;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.fin_x) begin
      mul_a = x_r[MA_W-1:0];
      mul_b = GAIN;
    end else if (cmd.fin_y) begin
      mul_a = y_r[MA_W-1:0];
      mul_b = GAIN;
    end else begin
      case (cmd.step[1:0])
        MUL_WZ: begin
          mul_a = MA_W'(qw_r);
          mul_b = MB_W'(qz_r);
        end
        MUL_XY: begin
          mul_a = MA_W'(qx_r);
          mul_b = MB_W'(qy_r);
        end
        MUL_YY: begin
          mul_a = MA_W'(qy_r);
          mul_b = MB_W'(qy_r);
        end
        MUL_ZZ: begin
          mul_a = MA_W'(qz_r);
          mul_b = MB_W'(qz_r);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_s = prod[ACC_W-1:0];

  // round half up, floor shift, saturate to 16 bits
  assign rnd = prod + FIN_RND;
  assign rsh = rnd[PROD_W-1:FIN_SHIFT];
  always_comb begin
    if (rsh > SAT_HI) begin
      sat = FLD_W'(SAT_HI);
    end else if (rsh < SAT_LO) begin
      sat = FLD_W'(SAT_LO);
    end else begin
      sat = rsh[FLD_W-1:0];
    end
  end

  // atan2 operands: y = 2(wz+xy), x = 1 - 2(yy+zz) at 2^30
  assign vinit_y = CW'(acc_y_r) <<< 1;
  assign vinit_x = ONE_Q30 - (CW'(acc_x_r) <<< 1);

  // rotation target is minus the yaw; beyond a quarter turn, swing by a half turn
  assign yaw_neg = FLD_W'(17'd0 - {1'b0, yaw_r});
  assign t32     = {yaw_neg, 16'h0000};
  assign flip    = t32[ZW-1] ^ t32[ZW-2];
  assign vel_x0  = CW'(vx_r) <<< VEL_SHIFT;
  assign vel_y0  = CW'(vy_r) <<< VEL_SHIFT;

  assign dx       = y_r >>> cmd.step;
  assign dy       = x_r >>> cmd.step;
  assign atan_v   = atan_lut(cmd.step);
  assign vec_mode = (cmd_r == CMD_ORIENT);
  assign y_pos    = !y_r[CW-1] && (y_r != '0);
  // s_pos: turn counterclockwise and take the angle down
  assign s_pos    = vec_mode ? !y_pos : !z_r[ZW-1];

  assign yaw_sum = z_r + YAW_RND;

  always_comb begin
    acc_y_nxt = acc_y_r;
    acc_x_nxt = acc_x_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    yaw_nxt   = yaw_r;
    fx_nxt    = fx_r;
    fy_nxt    = fy_r;
    if (cmd.mul_en) begin
      case (cmd.step[1:0])
        MUL_WZ:  acc_y_nxt = prod_s;
        MUL_XY:  acc_y_nxt = acc_y_r + prod_s;
        MUL_YY:  acc_x_nxt = prod_s;
        MUL_ZZ:  acc_x_nxt = acc_x_r + prod_s;
        default: acc_y_nxt = acc_y_r;
      endcase
    end
    if (cmd.vinit) begin
      if (vinit_x == '0 && vinit_y == '0) begin
        yaw_nxt = '0;
      end
      if (vinit_x[CW-1]) begin
        x_nxt = -vinit_x;
        y_nxt = -vinit_y;
        z_nxt = HALF_TURN;
      end else begin
        x_nxt = vinit_x;
        y_nxt = vinit_y;
        z_nxt = '0;
      end
    end
    if (cmd.rinit) begin
      x_nxt = flip ? -vel_x0 : vel_x0;
      y_nxt = flip ? -vel_y0 : vel_y0;
      z_nxt = flip ? t32 + HALF_TURN : t32;
    end
    if (cmd.iter) begin
      if (s_pos) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_v;
      end
    end
    if (cmd.yaw_wr) begin
      yaw_nxt = yaw_sum[ZW-1:ZW-FLD_W];
    end
    if (cmd.fin_x) begin
      fx_nxt = sat;
    end
    if (cmd.fin_y) begin
      fy_nxt = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r <= '0;
    end else begin
      yaw_r <= yaw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      qx_r  <= in_quat_x;
      qy_r  <= in_quat_y;
      qz_r  <= in_quat_z;
      qw_r  <= in_quat_w;
      vx_r  <= in_vel_x;
      vy_r  <= in_vel_y;
    end
    acc_y_r <= acc_y_nxt;
    acc_x_r <= acc_x_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    fx_r    <= fx_nxt;
    fy_r    <= fy_nxt;
    if (cmd.load_out) begin
      ox_r <= fx_r;
      oy_r <= fy_r;
      os_r <= spin_rate;
    end
  end

  assign status.is_vel   = (cmd_r == CMD_VEL);
  assign status.vec_zero = (vinit_x == '0) && (vinit_y == '0);

  assign out_vel_x = ox_r;
  assign out_vel_y = oy_r;
  assign out_spin  = os_r;

endmodule

[rtl/yaw_frame_velocity_rotator.sv]
// Top level of the yaw-frame velocity rotator: channels, register port, controller, datapath.
//
//   channel  dir  beat
//   in_ch    in   command, quat_x/y/z/w (Q1.15), vel_x/y (Q8.8)
//   out_ch   out  out_vel_x, out_vel_y, out_spin (Q8.8)
//   cfg_*    in   APB write/read of spin_rate at byte address 0
//
// One beat at a time. A velocity command runs the CORDIC rotation and the gain
// correction of x and y into the output register; an orientation update forms
// four products on the shared multiplier, then runs the iterative CORDIC into
// the stored yaw. The controller returns to idle before the next beat is taken.
// The output register lets the next beat in while a result waits.
// rst_n is synchronous; it clears the stored yaw, spin_rate and control state.
module yaw_frame_velocity_rotator (
  input  logic                          clk,
  input  logic                          rst_n,
  yfv_in_if.sink                        in_ch,
  yfv_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [yfv_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [yfv_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [yfv_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import yfv_pkg::*;

  yfv_cmd_t                cmd;
  yfv_status_t             status;
  logic signed [FLD_W-1:0] spin_r;
  logic                    spin_sel;

  assign cfg_pready = 1'b1;
  assign spin_sel   = (cfg_paddr[ADDR_W-1:2] == REG_SPIN_RATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && spin_sel) begin
      spin_r <= cfg_pwdata[FLD_W-1:0];
    end
  end

  assign cfg_prdata = spin_sel ? {{(PDATA_W-FLD_W){1'b0}}, spin_r} : '0;

  yfv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  yfv_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_command (in_ch.command),
    .in_quat_x  (in_ch.quat_x),
    .in_quat_y  (in_ch.quat_y),
    .in_quat_z  (in_ch.quat_z),
    .in_quat_w  (in_ch.quat_w),
    .in_vel_x   (in_ch.vel_x),
    .in_vel_y   (in_ch.vel_y),
    .spin_rate  (spin_r),
    .out_vel_x  (out_ch.out_vel_x),
    .out_vel_y  (out_ch.out_vel_y),
    .out_spin   (out_ch.out_spin)
  );

`ifndef ASSERT_OFF
  // one beat in flight: no second acceptance right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while previous beat still in work");

  // controller phases never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.mul_en, cmd.vinit, cmd.rinit, cmd.iter,
              cmd.yaw_wr, cmd.fin_x, cmd.fin_y, cmd.load_out}))
    else $error("overlapping datapath commands");

  // a result appears only after the output register was loaded
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result valid without output load");
`endif

endmodule

[sim/yfv_rotation_checker.sv]
// Scoreboard for the yaw-frame velocity rotator: tracks yaw and spin rate, predicts and checks each result beat.
module yfv_rotation_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  yfv_in_if                           cmd_mon,
  yfv_out_if                          res_mon,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [yfv_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [yfv_pkg::PDATA_W-1:0] cfg_pwdata,
  input  logic [yfv_pkg::PDATA_W-1:0] cfg_prdata,
  output int                          mismatches,
  output int                          outstanding
);
  import yfv_pkg::*;

  localparam int ATAN_LEN  = 24;
  localparam int ROT_STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin;
  } velocity_t;

  // atan(2^-k), 2^32 per turn
  logic [31:0] atan_turn [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  logic [15:0] heading;
  logic [15:0] spin_now;
  velocity_t   expected_vel [$];

  // vectoring CORDIC on atan2(2(wz+xy), 1-2(y^2+z^2)), operands at 2^30
  function automatic logic [15:0] quat_to_yaw(input logic signed [15:0] qx, qy, qz, qw);
    longint      ax, ay, x_sh, y_sh;
    logic [31:0] ang, rnd;
    int          k;
    ay  = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
    ax  = (64'sd1 <<< 30) - 2 * (longint'(qy) * longint'(qy) + longint'(qz) * longint'(qz));
    ang = '0;
    if (ax == 0 && ay == 0) return '0;
    if (ax < 0) begin
      ax  = -ax;
      ay  = -ay;
      ang = 32'h8000_0000;
    end
    for (k = 0; k < ROT_STEPS; k++) begin
      y_sh = ay >>> k;
      x_sh = ax >>> k;
      if (ay > 0) begin
        ax  += y_sh;
        ay  -= x_sh;
        ang += atan_turn[k];
      end else begin
        ax  -= y_sh;
        ay  += x_sh;
        ang -= atan_turn[k];
      end
    end
    rnd = ang + 32'h0000_8000;
    return rnd[31:16];
  endfunction

  // gain correction, round half up at bit 40, saturate to Q8.8
  function automatic logic signed [15:0] gain_round(input longint v);
    longint r;
    r = (v * 64'sd2608131496 + (64'sd1 <<< 39)) >>> 40;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic velocity_t rotate_by_yaw(input logic signed [15:0] vx, vy,
                                              input logic [15:0] yaw, spin);
    longint      px, py, x_sh, y_sh, t;
    logic [15:0] neg_yaw;
    logic [31:0] tgt;
    int          k;
    velocity_t   r;
    px      = longint'(vx) * 256;
    py      = longint'(vy) * 256;
    neg_yaw = -yaw;
    tgt     = {neg_yaw, 16'h0000};
    // beyond a quarter turn: fold by a half turn and negate the vector
    if (tgt[31:30] == 2'b01 || tgt[31:30] == 2'b10) begin
      px  = -px;
      py  = -py;
      tgt = tgt + 32'h8000_0000;
    end
    t = longint'(signed'(tgt));
    for (k = 0; k < ROT_STEPS; k++) begin
      y_sh = py >>> k;
      x_sh = px >>> k;
      if (t >= 0) begin
        px -= y_sh;
        py += x_sh;
        t  -= longint'(atan_turn[k]);
      end else begin
        px += y_sh;
        py -= x_sh;
        t  += longint'(atan_turn[k]);
      end
    end
    r.vel_x = gain_round(px);
    r.vel_y = gain_round(py);
    r.spin  = spin;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [15:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    velocity_t want;
    if (!rst_n) begin
      heading    = '0;
      spin_now   = '0;
      mismatches = 0;
      expected_vel.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[ADDR_W-1:2] == REG_SPIN_RATE && cfg_paddr[1:0] == 2'b00) begin
        if (cfg_pwrite) begin
          spin_now = cfg_pwdata[15:0];
        end else begin
          compare_field("spin_rate", spin_now, cfg_prdata[15:0]);
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_vel.size() == 0) begin
          $error("result beat with no pending velocity command");
          mismatches++;
        end else begin
          want = expected_vel.pop_front();
          compare_field("out_vel_x", want.vel_x, res_mon.out_vel_x);
          compare_field("out_vel_y", want.vel_y, res_mon.out_vel_y);
          compare_field("out_spin", want.spin, res_mon.out_spin);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_mon.command == CMD_VEL) begin
          expected_vel.push_back(rotate_by_yaw(cmd_mon.vel_x, cmd_mon.vel_y, heading, spin_now));
        end else begin
          heading = quat_to_yaw(cmd_mon.quat_x, cmd_mon.quat_y, cmd_mon.quat_z, cmd_mon.quat_w);
        end
      end
    end
    outstanding = expected_vel.size();
  end

endmodule

[sim/yaw_frame_velocity_rotator_tb.sv]
// Testbench top for the yaw-frame velocity rotator: clock, reset, stimulus, register writes, verdict.
module yaw_frame_velocity_rotator_tb;
  import yfv_pkg::*;

  localparam int SETTLE_CYCLES    = CORDIC_STEPS + 24;  // covers the orientation path
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 175;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic               cfg_pready;
  logic [ADDR_W-1:0]  cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 mismatches;
  int                 outstanding;
  int                 cycles;

  yfv_in_if  in_bus ();
  yfv_out_if out_bus ();

  always #1 clk = ~clk;

  yaw_frame_velocity_rotator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  yfv_rotation_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_bus),
    .res_mon     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("yaw_frame_velocity_rotator_tb: errors");
      $finish;
    end
  end

  // valid stays high from beat to beat unless an idle cycle is drawn
  task automatic send_beat(input logic cmd, input logic [15:0] qx, qy, qz, qw, vx, vy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.quat_x  <= qx;
    in_bus.quat_y  <= qy;
    in_bus.quat_z  <= qz;
    in_bus.quat_w  <= qw;
    in_bus.vel_x   <= vx;
    in_bus.vel_y   <= vy;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // unused fields carry noise
  task automatic orient(input logic [15:0] qx, qy, qz, qw);
    send_beat(CMD_ORIENT, qx, qy, qz, qw, 16'($urandom), 16'($urandom));
  endtask

  task automatic command_velocity(input logic [15:0] vx, vy);
    send_beat(CMD_VEL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), vx, vy);
  endtask

  task automatic cfg_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_spin(input logic [15:0] val);
    cfg_access(1'b1, REG_SPIN_RATE, val);
    cfg_access(1'b0, REG_SPIN_RATE, 16'h0000);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return 16'($urandom_range(511)) - 16'd256;
    endcase
  endfunction

  task automatic random_beat();
    int          pick;
    logic [15:0] r;
    pick = $urandom_range(99);
    r    = 16'($urandom_range(32767)) - 16'd16384;
    if (pick < 30) begin
      orient(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 40) begin
      // planar rotation: yaw only
      orient(16'h0000, 16'h0000, 16'($urandom), 16'($urandom));
    end else if (pick < 44) begin
      // both atan2 operands vanish
      orient(r, 16'h4000, 16'h4000, -r);
    end else if (pick < 85) begin
      command_velocity(16'($urandom), 16'($urandom));
    end else begin
      command_velocity(edge_value(), edge_value());
    end
  endtask

  initial begin
    int ph;
    int n;
    in_bus.valid   = 1'b0;
    in_bus.command = CMD_ORIENT;
    in_bus.quat_x  = '0;
    in_bus.quat_y  = '0;
    in_bus.quat_z  = '0;
    in_bus.quat_w  = '0;
    in_bus.vel_x   = '0;
    in_bus.vel_y   = '0;
    out_bus.ready  = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_spin(16'h8000);
    cfg_access(1'b1, REG_UNMAPPED, 16'h1234);  // must not touch spin_rate
    cfg_access(1'b0, REG_UNMAPPED, 16'h0000);

    // directed: identity, vanishing operands, quarter and half turns, saturation
    orient(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    command_velocity(16'h7fff, 16'h8000);
    orient(16'h0000, 16'h4000, 16'h4000, 16'h0000);
    command_velocity(16'h8000, 16'h8000);
    orient(16'h0000, 16'h0000, 16'h5a82, 16'h5a82);
    command_velocity(16'h7fff, 16'h0000);
    orient(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    command_velocity(16'h7fff, 16'h7fff);
    command_velocity(16'h8000, 16'h7fff);
    orient(16'h0000, 16'h0000, 16'h30fc, 16'h7642);
    command_velocity(16'h7fff, 16'h7fff);
    orient(16'h0000, 16'h0000, 16'hcf04, 16'h7642);
    command_velocity(16'h8000, 16'h8000);
    orient(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    command_velocity(16'h0000, 16'h0000);
    orient(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    command_velocity(16'h0001, 16'hffff);
    orient(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    command_velocity(16'h0100, 16'hff00);
    orient(16'h0000, 16'h0000, 16'h5a82, 16'ha57e);
    command_velocity(16'h1234, 16'hedcc);
    orient(16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    command_velocity(16'h7fff, 16'h8000);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_spin(16'h7fff);
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
          set_spin(16'h0000);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
          set_spin(16'($urandom));
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
          set_spin(16'($urandom));
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_beat();
        // hold off once until every pending result is out
        if (ph == 1 && n == RANDOM_PER_PHASE / 2) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("yaw_frame_velocity_rotator_tb: clean");
    end else begin
      $display("yaw_frame_velocity_rotator_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/yfv_pkg.sv
rtl/yfv_in_if.sv
rtl/yfv_out_if.sv
rtl/yfv_ctrl.sv
rtl/yfv_datapath.sv
rtl/yaw_frame_velocity_rotator.sv
sim/yfv_rotation_checker.sv
sim/yaw_frame_velocity_rotator_tb.sv
